>>> rtl/vector_rotate_about_axis_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector rotation block
// Shared property forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_ABOUT_AXIS_ASSERT_SVH
`define VECTOR_ROTATE_ABOUT_AXIS_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define VRA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define VRA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg
// Constants, stage positions, data types and tables of the vector rotation.
// ----------------------------------------------------------------------------
package vra_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ROTATION_STAGES = 24;

    localparam int FIELD_W = 32;
    localparam int TOL_W   = 16;
    localparam int IN_W    = 7 * FIELD_W;
    localparam int OUT_W   = 3 * FIELD_W;

    // Pipeline stage positions, counted in registers after the accepting edge.
    localparam int SQ_CELLS  = 32;
    localparam int DIV_CELLS = 31;
    localparam int ROT_LAT   = 2;
    localparam int T_SQ_IN   = 2;
    localparam int T_ERR     = T_SQ_IN + 1;
    localparam int T_SQ_OUT  = T_SQ_IN + SQ_CELLS;
    localparam int T_DIV_SET = T_SQ_OUT + 1;
    localparam int T_DIV_OUT = T_DIV_SET + DIV_CELLS;
    localparam int T_RATIO   = T_DIV_OUT + 1;
    localparam int T_CD_IN   = T_DIV_OUT - ROTATION_STAGES;
    localparam int T_LAST    = T_RATIO + 5 * ROT_LAT;

    localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;
    localparam logic signed [63:0] COMP_LIM  = 64'sd4294967295;
    localparam logic signed [63:0] COMP_NLIM = -COMP_LIM;
    localparam logic signed [63:0] SAT_HI =
        (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef logic signed [32:0] comp_t;
    typedef logic signed [31:0] trig_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec3_t;

    typedef struct packed {
        logic [63:0] v;
        logic [34:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [33:0] r;
        logic [31:0] den;
        logic [30:0] q;
        logic        ovf;
    } dv_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } cd_t;

    // arctan(2^-i) in binary-angle units
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0: a = 32'd536870912;
            5'd1: a = 32'd316933406;
            5'd2: a = 32'd167458907;
            5'd3: a = 32'd85004756;
            5'd4: a = 32'd42667331;
            5'd5: a = 32'd21354465;
            5'd6: a = 32'd10679838;
            5'd7: a = 32'd5340245;
            5'd8: a = 32'd2670163;
            5'd9: a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41721;
            5'd15: a = 32'd20860;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2607;
            5'd19: a = 32'd1303;
            5'd20: a = 32'd651;
            5'd21: a = 32'd325;
            5'd22: a = 32'd162;
            5'd23: a = 32'd81;
            5'd24: a = 32'd40;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd2;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/vra_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vra_sqrt_cell
// One digit step of the integer square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module vra_sqrt_cell import vra_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  sq_t  d_in,
    output sq_t  d_out
);

    sq_t         d_reg;
    sq_t         d_next;
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        ge;

    always_comb begin
        rem2        = {d_in.rem[32:0], d_in.v[63:62]};
        trial       = {1'b0, d_in.root, 2'b01};
        ge          = (rem2 >= trial);
        d_next.v    = {d_in.v[61:0], 2'b00};
        d_next.rem  = ge ? (rem2 - trial) : rem2;
        d_next.root = {d_in.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> rtl/vra_div_cell.sv
// ----------------------------------------------------------------------------
// vra_div_cell
// One restoring division step, producing one quotient bit.
// ----------------------------------------------------------------------------
module vra_div_cell import vra_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  dv_t  d_in,
    output dv_t  d_out
);

    dv_t         d_reg;
    dv_t         d_next;
    logic [33:0] diff;
    logic        ge;

    always_comb begin
        ge         = (d_in.r >= {2'b00, d_in.den});
        diff       = d_in.r - {2'b00, d_in.den};
        d_next.r   = ge ? {diff[32:0], 1'b0} : {d_in.r[32:0], 1'b0};
        d_next.den = d_in.den;
        d_next.q   = {d_in.q[29:0], ge};
        d_next.ovf = d_in.ovf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> rtl/vra_cordic_cell.sv
// ----------------------------------------------------------------------------
// vra_cordic_cell
// One CORDIC micro-rotation in rotation mode; the stage index is tied at the instance.
// ----------------------------------------------------------------------------
module vra_cordic_cell import vra_pkg::*; (
    input  logic       aclk,
    input  logic       en,
    input  logic [4:0] stage_idx,
    input  cd_t        d_in,
    output cd_t        d_out
);

    cd_t                d_reg;
    cd_t                d_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;

    always_comb begin
        dx = d_in.y >>> stage_idx;
        dy = d_in.x >>> stage_idx;
        at = signed'({2'b00, atan_entry(stage_idx)});
        d_next.flip = d_in.flip;
        if (!d_in.z[33]) begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - at;
        end else begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> rtl/vra_rot.sv
// ----------------------------------------------------------------------------
// vra_rot
// Plane rotation of a vector about z or y: products, then round, shift and clamp.
// ----------------------------------------------------------------------------
module vra_rot import vra_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  logic  sel_y,
    input  vec3_t v_in,
    input  trig_t s_in,
    input  trig_t c_in,
    output vec3_t v_out
);

    comp_t              p;
    comp_t              q;
    comp_t              r;
    logic signed [63:0] pc_reg;
    logic signed [63:0] qs_reg;
    logic signed [63:0] ps_reg;
    logic signed [63:0] qc_reg;
    comp_t              r_reg;
    logic               sel_y_reg;
    logic signed [63:0] sum_p;
    logic signed [63:0] sum_q;
    comp_t              np;
    comp_t              nq;
    vec3_t              v_reg;
    vec3_t              v_next;

    function automatic comp_t clamp_comp(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v;
        if (v > COMP_LIM) begin
            w = COMP_LIM;
        end else if (v < COMP_NLIM) begin
            w = COMP_NLIM;
        end
        return w[32:0];
    endfunction

    // About y the pair is (z, x); about z it is (x, y).
    always_comb begin
        p = sel_y ? v_in.z : v_in.x;
        q = sel_y ? v_in.x : v_in.y;
        r = sel_y ? v_in.y : v_in.z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg    <= p * c_in;
            qs_reg    <= q * s_in;
            ps_reg    <= p * s_in;
            qc_reg    <= q * c_in;
            r_reg     <= r;
            sel_y_reg <= sel_y;
        end
    end

    always_comb begin
        sum_p = pc_reg - qs_reg + ROUND_HALF;
        sum_q = ps_reg + qc_reg + ROUND_HALF;
        np    = clamp_comp(sum_p >>> 30);
        nq    = clamp_comp(sum_q >>> 30);
        if (sel_y_reg) begin
            v_next.x = nq;
            v_next.y = r_reg;
            v_next.z = np;
        end else begin
            v_next.x = np;
            v_next.y = nq;
            v_next.z = r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
        end
    end

    assign v_out = v_reg;

endmodule

>>> rtl/vector_rotate_about_axis.sv
// ----------------------------------------------------------------------------
// vector_rotate_about_axis
// Rotates a Q16.16 vector about an arbitrary axis by a binary angle, one transfer a cycle.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   s_*       in          vector, axis and angle (tdata)
//   m_*       out         rotated vector (tdata), zero-axis status (tuser)
//   cfg_*     in          zero_tolerance register write
//
// The block takes one transfer per clock while the skid register is empty and holds
// many items in flight at once. From the input transfer, m_tvalid waits on the chain
// of 32 square-root cells, the chain of 31 divider cells and five rotation units, each
// with product and output registers. The angle CORDIC runs alongside the dividers.
// Reset (synchronous, aresetn low) empties the pipeline and sets zero_tolerance to 1.
// A stalled result waits in the output register while a skid register takes the
// next one; the whole chain halts only while the skid register is full.
//
module vector_rotate_about_axis import vra_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration: zero_tolerance, Q16.16 length
    input  logic               cfg_we,
    input  logic [TOL_W-1:0]   cfg_wdata,
    // Input stream. tdata from bit 0: vec_x, vec_y, vec_z, axis_x, axis_y,
    // axis_z, angle (32 bits each)
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    // Output stream. tdata from bit 0: out_x, out_y, out_z (32 bits each)
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    // tuser: status (1 when the axis counted as zero)
    output logic               m_tuser
);

    // Side data that travels along with each item through the pipeline.
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic [31:0]        angle;
        logic [31:0]        tol2;
        logic               err;
        trig_t              st;
        trig_t              ct;
        trig_t              sg;
        trig_t              cg;
        trig_t              sa;
        trig_t              ca;
    } carry_t;

    logic [TOL_W-1:0] zero_tol_reg;
    logic             en;

    logic               vld_reg [1:T_LAST];
    carry_t             carry_reg [1:T_LAST];
    carry_t             carry_stage_next [1:T_LAST];
    carry_t             carry_next;

    logic signed [31:0] in_vx, in_vy, in_vz, in_ax, in_ay, in_az;
    logic [31:0]        in_angle;
    logic [31:0]        mx, my, mz;
    logic [63:0]        mx2_reg, my2_reg, mz2_reg;
    logic [63:0]        s_reg, p_reg;
    logic               err_next;

    sq_t sq_s [0:SQ_CELLS];
    sq_t sq_p [0:SQ_CELLS];

    dv_t div_set_reg [0:3];
    dv_t div_set_next [0:3];
    dv_t dv_c [0:3][0:DIV_CELLS];

    cd_t cd [0:ROTATION_STAGES];

    trig_t ratio_st, ratio_ct, ratio_sg, ratio_cg, cd_sin, cd_cos;

    vec3_t v_rot [0:5];

    logic [OUT_W-1:0] last_data;
    logic             last_user;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic             m_user_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             skid_user_reg;

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    // Divider entry: the quotient is clamped to one anyway, so a numerator of
    // twice the denominator or more is flagged and the step chain starts empty.
    function automatic dv_t make_div(input logic [31:0] mag, input logic [31:0] den);
        dv_t d;
        d.ovf = ({1'b0, mag} >= {den, 1'b0});
        d.r   = d.ovf ? 34'd0 : {2'b00, mag};
        d.den = den;
        d.q   = 31'd0;
        return d;
    endfunction

    function automatic trig_t ratio_of(input dv_t d, input logic neg);
        logic [30:0] qm;
        trig_t       val;
        qm = (d.ovf || d.q > 31'h4000_0000) ? 31'h4000_0000 : d.q;
        val = (d.den == 32'd0) ? 32'sd0 : signed'({1'b0, qm});
        return neg ? -val : val;
    endfunction

    function automatic trig_t clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] w;
        w = v;
        if (v > 34'sd1073741824) begin
            w = 34'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            w = -34'sd1073741824;
        end
        return w[31:0];
    endfunction

    function automatic logic [31:0] sat_coord(input comp_t v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return w[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_tol_reg <= TOL_W'(1);
        end else if (cfg_we) begin
            zero_tol_reg <= cfg_wdata;
        end
    end

    // The chain moves whenever the skid register is free to catch a result.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Input unpacking and squares of the axis components
    // ------------------------------------------------------------------
    assign in_vx    = s_tdata[31:0];
    assign in_vy    = s_tdata[63:32];
    assign in_vz    = s_tdata[95:64];
    assign in_ax    = s_tdata[127:96];
    assign in_ay    = s_tdata[159:128];
    assign in_az    = s_tdata[191:160];
    assign in_angle = s_tdata[223:192];

    assign mx = abs32(in_ax);
    assign my = abs32(in_ay);
    assign mz = abs32(in_az);

    always_ff @(posedge aclk) begin
        if (en) begin
            mx2_reg <= mx * mx;
            my2_reg <= my * my;
            mz2_reg <= mz * mz;
            p_reg   <= mx2_reg + my2_reg;
            s_reg   <= mx2_reg + my2_reg + mz2_reg;
        end
    end

    // The squared length is compared against the squared tolerance; a zero
    // axis is an error even with a tolerance of zero.
    assign err_next = (s_reg == 64'd0) ||
                      (s_reg < {32'd0, carry_reg[T_SQ_IN].tol2});

    // ------------------------------------------------------------------
    // Integer square roots of the full and the x-y squared lengths
    // ------------------------------------------------------------------
    assign sq_s[0] = '{v: s_reg, rem: 35'd0, root: 32'd0};
    assign sq_p[0] = '{v: p_reg, rem: 35'd0, root: 32'd0};

    for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
        vra_sqrt_cell u_sq_s (
            .aclk  (aclk),
            .en    (en),
            .d_in  (sq_s[i]),
            .d_out (sq_s[i+1])
        );
        vra_sqrt_cell u_sq_p (
            .aclk  (aclk),
            .en    (en),
            .d_in  (sq_p[i]),
            .d_out (sq_p[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Four ratio dividers: cos/sin of gamma over the length, cos/sin of
    // theta over the x-y length.
    // ------------------------------------------------------------------
    always_comb begin
        div_set_next[0] = make_div(abs32(carry_reg[T_SQ_OUT].az), sq_s[SQ_CELLS].root);
        div_set_next[1] = make_div(sq_p[SQ_CELLS].root, sq_s[SQ_CELLS].root);
        div_set_next[2] = make_div(abs32(carry_reg[T_SQ_OUT].ax), sq_p[SQ_CELLS].root);
        div_set_next[3] = make_div(abs32(carry_reg[T_SQ_OUT].ay), sq_p[SQ_CELLS].root);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                div_set_reg[c] <= div_set_next[c];
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_div
        assign dv_c[c][0] = div_set_reg[c];
        for (genvar i = 0; i < DIV_CELLS; i++) begin : g_step
            vra_div_cell u_div (
                .aclk  (aclk),
                .en    (en),
                .d_in  (dv_c[c][i]),
                .d_out (dv_c[c][i+1])
            );
        end
    end

    assign ratio_cg = ratio_of(dv_c[0][DIV_CELLS], carry_reg[T_DIV_OUT].az[31]);
    assign ratio_sg = ratio_of(dv_c[1][DIV_CELLS], 1'b0);
    assign ratio_st = ratio_of(dv_c[3][DIV_CELLS], carry_reg[T_DIV_OUT].ay[31]);
    // With the axis along z the theta turns become the identity.
    assign ratio_ct = (dv_c[2][DIV_CELLS].den == 32'd0) ? Q30_ONE :
                      ratio_of(dv_c[2][DIV_CELLS], carry_reg[T_DIV_OUT].ax[31]);

    // ------------------------------------------------------------------
    // Angle sine and cosine. Angles in the left half-plane are turned by
    // half a circle first and the results negated at the end.
    // ------------------------------------------------------------------
    always_comb begin
        logic [31:0] u;
        logic [31:0] u_q;
        logic [31:0] u_f;
        logic        flip;
        u      = carry_reg[T_CD_IN].angle;
        u_q    = u + 32'h4000_0000;
        flip   = u_q[31];
        u_f    = flip ? (u + 32'h8000_0000) : u;
        cd[0].x    = CORDIC_K;
        cd[0].y    = 34'sd0;
        cd[0].z    = 34'(signed'(u_f));
        cd[0].flip = flip;
    end

    for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cordic
        vra_cordic_cell u_cd (
            .aclk      (aclk),
            .en        (en),
            .stage_idx (5'(i)),
            .d_in      (cd[i]),
            .d_out     (cd[i+1])
        );
    end

    assign cd_cos = clamp_q30(cd[ROTATION_STAGES].flip ? -cd[ROTATION_STAGES].x
                                                       : cd[ROTATION_STAGES].x);
    assign cd_sin = clamp_q30(cd[ROTATION_STAGES].flip ? -cd[ROTATION_STAGES].y
                                                       : cd[ROTATION_STAGES].y);

    // ------------------------------------------------------------------
    // Side-data line and valid bits
    // ------------------------------------------------------------------
    always_comb begin
        carry_next       = '0;
        carry_next.vx    = in_vx;
        carry_next.vy    = in_vy;
        carry_next.vz    = in_vz;
        carry_next.ax    = in_ax;
        carry_next.ay    = in_ay;
        carry_next.az    = in_az;
        carry_next.angle = in_angle;
        carry_next.tol2  = 32'(zero_tol_reg) * 32'(zero_tol_reg);
    end

    // Each stage takes its neighbor's side data; the error flag and the
    // sines and cosines join the line at their own stages.
    always_comb begin
        carry_stage_next[1] = carry_next;
        for (int k = 2; k <= T_LAST; k++) begin
            carry_stage_next[k] = carry_reg[k-1];
        end
        carry_stage_next[T_ERR].err  = err_next;
        carry_stage_next[T_RATIO].st = ratio_st;
        carry_stage_next[T_RATIO].ct = ratio_ct;
        carry_stage_next[T_RATIO].sg = ratio_sg;
        carry_stage_next[T_RATIO].cg = ratio_cg;
        carry_stage_next[T_RATIO].sa = cd_sin;
        carry_stage_next[T_RATIO].ca = cd_cos;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 1; k <= T_LAST; k++) begin
                carry_reg[k] <= carry_stage_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= T_LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= T_LAST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Five rotations: -theta about z, -gamma about y, the angle about z,
    // +gamma about y, +theta about z.
    // ------------------------------------------------------------------
    assign v_rot[0].x = 33'(carry_reg[T_RATIO].vx);
    assign v_rot[0].y = 33'(carry_reg[T_RATIO].vy);
    assign v_rot[0].z = 33'(carry_reg[T_RATIO].vz);

    vra_rot u_rot_theta_in (
        .aclk  (aclk),
        .en    (en),
        .sel_y (1'b0),
        .v_in  (v_rot[0]),
        .s_in  (-carry_reg[T_RATIO].st),
        .c_in  (carry_reg[T_RATIO].ct),
        .v_out (v_rot[1])
    );

    vra_rot u_rot_gamma_in (
        .aclk  (aclk),
        .en    (en),
        .sel_y (1'b1),
        .v_in  (v_rot[1]),
        .s_in  (-carry_reg[T_RATIO+ROT_LAT].sg),
        .c_in  (carry_reg[T_RATIO+ROT_LAT].cg),
        .v_out (v_rot[2])
    );

    vra_rot u_rot_angle (
        .aclk  (aclk),
        .en    (en),
        .sel_y (1'b0),
        .v_in  (v_rot[2]),
        .s_in  (carry_reg[T_RATIO+2*ROT_LAT].sa),
        .c_in  (carry_reg[T_RATIO+2*ROT_LAT].ca),
        .v_out (v_rot[3])
    );

    vra_rot u_rot_gamma_out (
        .aclk  (aclk),
        .en    (en),
        .sel_y (1'b1),
        .v_in  (v_rot[3]),
        .s_in  (carry_reg[T_RATIO+3*ROT_LAT].sg),
        .c_in  (carry_reg[T_RATIO+3*ROT_LAT].cg),
        .v_out (v_rot[4])
    );

    vra_rot u_rot_theta_out (
        .aclk  (aclk),
        .en    (en),
        .sel_y (1'b0),
        .v_in  (v_rot[4]),
        .s_in  (carry_reg[T_RATIO+4*ROT_LAT].st),
        .c_in  (carry_reg[T_RATIO+4*ROT_LAT].ct),
        .v_out (v_rot[5])
    );

    // ------------------------------------------------------------------
    // Saturation, zero-axis bypass, output and skid registers
    // ------------------------------------------------------------------
    always_comb begin
        if (carry_reg[T_LAST].err) begin
            last_data = {carry_reg[T_LAST].vz, carry_reg[T_LAST].vy, carry_reg[T_LAST].vx};
        end else begin
            last_data = {sat_coord(v_rot[5].z), sat_coord(v_rot[5].y),
                         sat_coord(v_rot[5].x)};
        end
        last_user = carry_reg[T_LAST].err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                m_data_reg     <= skid_data_reg;
                m_user_reg     <= skid_user_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[T_LAST];
                m_data_reg  <= last_data;
                m_user_reg  <= last_user;
            end
        end else if (en && vld_reg[T_LAST]) begin
            // The output is stalled: park the arriving result.
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= last_data;
            skid_user_reg  <= last_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/vra_checker.sv
// ----------------------------------------------------------------------------
// vra_checker
// Port-level checks of the vector rotation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector_rotate_about_axis_assert.svh"

module vra_checker import vra_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    `VRA_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `VRA_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `VRA_ASSERT_SAME(a_ready_low_cause, !s_tready, $past(m_tvalid && !m_tready), "input held off without an output stall")
    `VRA_ASSERT_NEXT(a_skid_drains, m_tvalid && m_tready && !s_tready, s_tready, "skid register not drained after a transfer")

endmodule

bind vector_rotate_about_axis vra_checker u_vra_checker (.*);
